>>> design/qlt_pkg.sv
// Package for the quoted line tokenizer: result record, mode and kind codes,
// character constants and output queue depth.
// No dependencies.
`default_nettype none

package qlt_pkg;

    // Characters with a special meaning to the parser
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [7:0] MAX_TOKENS_RESET = 8'd16;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } kind_t;

    // Parser modes, one-hot
    typedef enum logic [4:0] {
        MODE_BETWEEN = 5'b00001,
        MODE_BARE    = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_QSEEN   = 5'b01000,
        MODE_SKIP    = 5'b10000
    } mode_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        logic [7:0] token_index;
        logic       last;
    } result_t;

    // Results produced by one input byte
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Output queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

>>> design/qlt_parser.sv
// Per-byte parser of the quoted line tokenizer: mode, token count and limit
// registers, and the up to two results that each byte yields. Uses qlt_pkg.
`default_nettype none

module qlt_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata,
    input  wire logic          in_fire,
    input  wire logic [7:0]    in_ch,
    output qlt_pkg::push_t     push
);
    import qlt_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] max_tokens_reg;

    logic [7:0] lc_ch;
    logic       is_sep;
    logic       at_limit;
    result_t    r_byte, r_end, r_line;
    push_t      p;

    // Hold the token limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tokens_reg <= MAX_TOKENS_RESET;
        end else if (cfg_we) begin
            max_tokens_reg <= cfg_wdata;
        end
    end

    // Classify the byte
    assign is_sep   = (in_ch <= CH_SPACE);
    assign at_limit = (count_reg >= max_tokens_reg);
    assign lc_ch    = (in_ch >= CH_UC_A && in_ch <= CH_UC_Z) ? in_ch + CASE_OFS : in_ch;

    // Candidate results
    always_comb begin
        r_byte             = '0;
        r_byte.kind        = KIND_BYTE;
        r_byte.token_index = count_reg;
        r_byte.out_char    = in_ch;
        r_end              = '0;
        r_end.kind         = KIND_END;
        r_end.token_index  = count_reg;
        r_line             = '0;
        r_line.kind        = KIND_LINE;
        r_line.last        = 1'b1;
    end

    // Next mode, next count and results for this byte
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        p          = '0;
        if (in_ch == CH_NUL) begin
            mode_next  = MODE_BETWEEN;
            count_next = '0;
            if (mode_reg == MODE_BARE || mode_reg == MODE_QUOTED ||
                mode_reg == MODE_QSEEN) begin
                p.num = 2'd2;
                p.r0  = r_end;
                p.r1  = r_line;
                p.r1.token_index = count_reg + 8'd1;
            end else begin
                p.num = 2'd1;
                p.r0  = r_line;
                p.r0.token_index = count_reg;
            end
        end else begin
            case (mode_reg)
                MODE_BETWEEN: begin
                    if (!is_sep) begin
                        if (in_ch == CH_HASH || at_limit) begin
                            mode_next = MODE_SKIP;
                        end else if (in_ch == CH_QUOTE) begin
                            mode_next = MODE_QUOTED;
                        end else begin
                            mode_next = MODE_BARE;
                            p.num     = 2'd1;
                            p.r0      = r_byte;
                            p.r0.out_char = lc_ch;
                            p.r0.last = 1'b1;
                        end
                    end
                end
                MODE_BARE: begin
                    p.num = 2'd1;
                    if (is_sep || in_ch == CH_HASH) begin
                        mode_next  = is_sep ? MODE_BETWEEN : MODE_SKIP;
                        count_next = count_reg + 8'd1;
                        p.r0       = r_end;
                    end else begin
                        p.r0          = r_byte;
                        p.r0.out_char = lc_ch;
                    end
                    p.r0.last = 1'b1;
                end
                MODE_QUOTED: begin
                    if (in_ch == CH_QUOTE) begin
                        mode_next = MODE_QSEEN;
                    end else begin
                        p.num     = 2'd1;
                        p.r0      = r_byte;
                        p.r0.last = 1'b1;
                    end
                end
                MODE_QSEEN: begin
                    p.num = 2'd1;
                    if (in_ch == CH_QUOTE) begin
                        mode_next = MODE_QUOTED;
                        p.r0      = r_byte;
                    end else begin
                        mode_next  = MODE_BETWEEN;
                        count_next = count_reg + 8'd1;
                        p.r0       = r_end;
                    end
                    p.r0.last = 1'b1;
                end
                default: begin
                    mode_next = MODE_SKIP;
                end
            endcase
        end
    end

    // Advance the parser on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_BETWEEN;
            count_reg <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    assign push.num = in_fire ? p.num : 2'd0;
    assign push.r0  = p.r0;
    assign push.r1  = p.r1;

    // Two results only come from a line end that closes a token
    a_two_on_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == 2'd2) |-> (in_ch == CH_NUL && push.r0.kind == KIND_END))
        else $error("two results without line end");

    // Line end always clears the token count
    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_ch == CH_NUL) |=> (count_reg == 8'd0))
        else $error("token count not cleared at line end");

endmodule

`default_nettype wire

>>> design/qlt_outq.sv
// Output queue of the quoted line tokenizer: takes up to two results per
// cycle and hands out one per cycle while out_ready is high. Uses qlt_pkg.
`default_nettype none

module qlt_outq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  qlt_pkg::push_t     push,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output qlt_pkg::result_t   out_res
);
    import qlt_pkg::*;

    result_t        q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg, count_next;
    logic           pop;
    logic [QAW-1:0] wr_ptr_1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = q_mem[rd_ptr_reg];
    // Room for a worst-case pair regardless of the output side
    assign room      = (count_reg <= QCW'(QDEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + QAW'(1);

    assign count_next = count_reg + QCW'(push.num) - QCW'(pop);

    // Store the results of the accepted byte
    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            q_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            q_mem[wr_ptr_1] <= push.r1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push.num);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Fill level never exceeds the storage
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QDEPTH))
        else $error("output queue overflow");

    // A pair pushed with no pop raises the level by two
    a_pair_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == 2'd2 && !pop) |=> (count_reg == $past(count_reg) + QCW'(2)))
        else $error("output queue level wrong after pair");

endmodule

`default_nettype wire

>>> design/quoted_line_tokenizer.sv
// Top level of the quoted line tokenizer: byte stream in, token stream out.
// Depends on qlt_pkg, qlt_parser and qlt_outq.
//
//  Port group   Dir  Content
//  s_axis_*     in   one byte a request; tdata[7:0] ch (0 ends the line)
//  m_axis_*     out  one result a request; tdata out_char, token_index;
//                    tuser kind; tlast marks last result of a byte
//  cfg_*        in   max_tokens write, taken at any edge with cfg_we high
//
// A byte is parsed in the cycle it is accepted and its results are queued
// behind any still waiting. One byte per cycle is accepted while the
// four-entry output queue has room for two results; the output side
// drains one result per cycle while m_axis_tready is high, and a line end
// that closes a token yields two results. Reset is synchronous, active
// low, and clears the parser mode, token count, limit (to 16) and queue.
`default_nettype none

module quoted_line_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [15:8] token_index
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last result of the byte
);
    import qlt_pkg::*;

    push_t   push;
    result_t out_res;
    logic    room;
    logic    in_fire;

    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && room;

    // Parse each accepted byte
    qlt_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_ch     (s_axis_tdata),
        .push      (push)
    );

    // Queue results toward the output
    qlt_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.token_index, out_res.out_char};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

>>> tb/quoted_line_tokenizer_tb.sv
// Self-checking testbench for quoted_line_tokenizer: streams lines of bytes in,
// predicts the token stream in step with each accepted byte and checks it.
// Depends on qlt_pkg and the quoted_line_tokenizer RTL.
`default_nettype none

module quoted_line_tokenizer_tb;

    import qlt_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 320;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_LINE_TOKENS = 258;
    localparam int MAX_REPORTS      = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Byte source and token expectations
    logic [7:0] pending_bytes_q [$];
    result_t    expected_tokens_q [$];
    int         bytes_loaded = 0;
    int         bytes_accepted = 0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    logic       in_fire = 1'b0;

    // Tokenizer state as predicted
    mode_t      pm = MODE_BETWEEN;
    logic [7:0] tok_cnt = 8'd0;
    logic [7:0] tok_limit = MAX_TOKENS_RESET;

    // Idle pattern state of both sides
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    // Directed line set: separators, case folding, high bytes, escaped quote,
    // swallowed byte, comment, unterminated quote, empty quoted token
    logic [7:0] directed_bytes [26] = '{
        8'h01, "A", "Z", 8'hFF, CH_SPACE, CH_QUOTE, "Q", CH_QUOTE, CH_QUOTE,
        CH_QUOTE, "X", "z", CH_HASH, "q", CH_NUL,
        CH_QUOTE, 8'h80, CH_NUL,
        "a", CH_NUL,
        CH_QUOTE, CH_QUOTE, CH_NUL,
        CH_HASH, CH_NUL,
        CH_NUL
    };

    quoted_line_tokenizer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] ch
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] out_char, [15:8] token_index
        .m_axis_tuser  (m_axis_tuser),    // [1:0] kind
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return c + CASE_OFS;
        return c;
    endfunction

    function automatic void add_token(input kind_t k, input logic [7:0] c,
                                      input logic [7:0] idx);
        result_t r;
        r.kind = k;
        r.out_char = c;
        r.token_index = idx;
        r.last = 1'b0;
        expected_tokens_q.push_back(r);
    endfunction

    // Advance the predicted parser by one byte and queue the tokens it emits
    task automatic tokenize_byte(input logic [7:0] ch);
        int      start_sz;
        result_t r;
        start_sz = expected_tokens_q.size();
        if (ch == CH_NUL) begin
            if (pm inside {MODE_BARE, MODE_QUOTED, MODE_QSEEN}) begin
                add_token(KIND_END, CH_NUL, tok_cnt);
                tok_cnt = tok_cnt + 8'd1;
            end
            add_token(KIND_LINE, CH_NUL, tok_cnt);
            pm = MODE_BETWEEN;
            tok_cnt = 8'd0;
        end else begin
            case (pm)
                MODE_BETWEEN: begin
                    if (ch > CH_SPACE) begin
                        if (ch == CH_HASH || tok_cnt >= tok_limit) begin
                            pm = MODE_SKIP;
                        end else if (ch == CH_QUOTE) begin
                            pm = MODE_QUOTED;
                        end else begin
                            add_token(KIND_BYTE, fold_case(ch), tok_cnt);
                            pm = MODE_BARE;
                        end
                    end
                end
                MODE_BARE: begin
                    if (ch <= CH_SPACE || ch == CH_HASH) begin
                        add_token(KIND_END, CH_NUL, tok_cnt);
                        tok_cnt = tok_cnt + 8'd1;
                        pm = (ch == CH_HASH) ? MODE_SKIP : MODE_BETWEEN;
                    end else begin
                        add_token(KIND_BYTE, fold_case(ch), tok_cnt);
                    end
                end
                MODE_QUOTED: begin
                    if (ch == CH_QUOTE)
                        pm = MODE_QSEEN;
                    else
                        add_token(KIND_BYTE, ch, tok_cnt);
                end
                MODE_QSEEN: begin
                    // doubled quote stays in the token, anything else closes it
                    if (ch == CH_QUOTE) begin
                        add_token(KIND_BYTE, ch, tok_cnt);
                        pm = MODE_QUOTED;
                    end else begin
                        add_token(KIND_END, CH_NUL, tok_cnt);
                        tok_cnt = tok_cnt + 8'd1;
                        pm = MODE_BETWEEN;
                    end
                end
                default: pm = MODE_SKIP;
            endcase
        end
        // mark the final token of this byte
        if (expected_tokens_q.size() > start_sz) begin
            r = expected_tokens_q.pop_back();
            r.last = 1'b1;
            expected_tokens_q.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Idle length: mostly none or short, now and then long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0)
            calm = $urandom_range(40, 120);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        pending_bytes_q.push_back(c);
        bytes_loaded++;
    endfunction

    function automatic logic [7:0] bare_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = 8'($urandom_range(CH_UC_A, CH_UC_Z));
            1:       c = 8'($urandom_range(8'h80, 8'hFF));
            default: c = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        if (c == CH_QUOTE || c == CH_HASH)
            c = "x";
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        return 8'($urandom_range(1, CH_SPACE));
    endfunction

    // Build one line of ntok tokens with random content; a last quoted token may be left unterminated
    task automatic gen_line(input int ntok);
        logic [7:0] c;
        repeat ($urandom_range(0, 2)) push_byte(sep_char());
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(0, 2) == 0) begin
                push_byte(CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(1, 255));
                    push_byte(c);
                    if (c == CH_QUOTE)
                        push_byte(CH_QUOTE);
                end
                // unterminated quote, or line end right after the closing quote
                if (t == ntok - 1 && $urandom_range(0, 5) == 0) begin
                    push_byte(CH_NUL);
                    return;
                end
                push_byte(CH_QUOTE);
                if (t == ntok - 1 && $urandom_range(0, 3) == 0) begin
                    push_byte(CH_NUL);
                    return;
                end
                c = 8'($urandom_range(1, 255));
                push_byte((c == CH_QUOTE) ? CH_SPACE : c);
                repeat ($urandom_range(0, 1)) push_byte(sep_char());
            end else begin
                repeat ($urandom_range(1, 5)) push_byte(bare_char());
                if (t != ntok - 1)
                    repeat ($urandom_range(1, 2)) push_byte(sep_char());
            end
        end
        case ($urandom_range(0, 3))
            0: begin
                push_byte(CH_HASH);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
            end
            1:       push_byte(sep_char());
            default: ;
        endcase
        push_byte(CH_NUL);
    endtask

    task automatic load_random(input int count);
        int target;
        target = bytes_loaded + count;
        while (bytes_loaded < target) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise line
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_NUL);
            end else if ($urandom_range(0, 9) == 0) begin
                gen_line($urandom_range(7, 20));
            end else begin
                gen_line($urandom_range(0, 6));
            end
        end
    endtask

    // Hold the sender until every byte is taken and every token has come out
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (bytes_accepted != bytes_loaded || expected_tokens_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Drive input bytes from the pending queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fire) begin
            // hold the request until taken
        end else if (send_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            send_gap--;
        end else if (pending_bytes_q.size() > 0) begin
            s_axis_tdata <= pending_bytes_q.pop_front();
            s_axis_tvalid <= 1'b1;
            send_gap = pick_gap(send_calm);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Drive result ready, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (!long_hold_done && bytes_accepted >= LONG_HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            recv_stall = pick_gap(recv_calm);
        end
    end

    // Check results, then predict from accepted bytes and register writes
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            pm = MODE_BETWEEN;
            tok_cnt = 8'd0;
            tok_limit = MAX_TOKENS_RESET;
            in_fire <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tokens_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual kind %0d char %0d index %0d last %0d",
                                 $time, m_axis_tuser, m_axis_tdata[7:0],
                                 m_axis_tdata[15:8], m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = expected_tokens_q.pop_front();
                    check_field("kind", int'(want.kind), int'(m_axis_tuser));
                    check_field("out_char", int'(want.out_char), int'(m_axis_tdata[7:0]));
                    check_field("token_index", int'(want.token_index),
                                int'(m_axis_tdata[15:8]));
                    check_field("last", int'(want.last), int'(m_axis_tlast));
                end
            end
            if (cfg_we)
                tok_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                tokenize_byte(s_axis_tdata);
                bytes_accepted++;
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limit: directed lines, then random lines
        foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
        load_random(RANDOM_PER_PHASE);
        wait_drained();

        // one token per line
        write_limit(8'd1);
        load_random(RANDOM_PER_PHASE);
        wait_drained();

        // widest limit, with one line that runs into it
        write_limit(8'd255);
        for (int i = 0; i < LONG_LINE_TOKENS; i++) begin
            push_byte(bare_char());
            push_byte(sep_char());
        end
        push_byte(CH_NUL);
        load_random(RANDOM_PER_PHASE);
        wait_drained();

        write_limit(8'($urandom_range(2, 20)));
        load_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (2 * SETTLE_CYCLES) @(negedge aclk);
        if (err_cnt == 0 && expected_tokens_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
